// ===== hw/rtl/ebr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the ellipse rasteriser.
`timescale 1ns / 1ps
`default_nettype none

package ebr_pkg;

  // Default field widths of the block.
  localparam int COORD_BITS_DEF = 10;
  localparam int AXIS_BITS_DEF  = 9;

  // Four mirrored points are emitted for every step.
  localparam int NUM_POINTS = 4;
  localparam int PT_W       = $clog2(NUM_POINTS);
  localparam logic [PT_W-1:0] PT_LAST = PT_W'(NUM_POINTS - 1);

  // Command carried in tuser on the input stream.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_start;
    logic            square;
    logic            init_err;
    logic            load_point;
    logic [PT_W-1:0] point_idx;
    logic            commit;
  } ebr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic out_free;
  } ebr_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ellipse_bresenham_raster.sv =====
// Top level of the Bresenham ellipse rasteriser: stream ports, controller and datapath.
//
//  Channel   Direction  Transaction carries
//  s_*       in         command (tuser), centre and semi-axes (tdata)
//  m_*       out        one mirrored point (tdata), last point of the ellipse (tlast)
//
// A start command is accepted and then passes through the set-up states ST_SQUARE
// (squares), ST_PROD (shared product a*a*b) and ST_ERR (initial error). A step is
// accepted and then emits its four points one at a time through the single output
// register. A step while idle is accepted and dropped. Reset empties the output
// register and leaves no ellipse in progress. When m_tready is low the point waits
// in the output register and the controller holds until it leaves.
`timescale 1ns / 1ps
`default_nettype none

module ellipse_bresenham_raster #(
  parameter int COORD_BITS = ebr_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = ebr_pkg::AXIS_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // center_x, center_y, semi_a, semi_b, zero padding
  input  wire logic [((2*COORD_BITS+2*AXIS_BITS+7)/8)*8-1:0] s_tdata,
  // command
  input  wire logic                       s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // point_x, point_y, zero padding
  output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] m_tdata,
  output logic                            m_tlast
);

  localparam int OUT_W    = COORD_BITS + 2;
  localparam int M_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  ebr_pkg::ebr_cmd_t    cmd;
  ebr_pkg::ebr_status_t status;

  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;

  ebr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tuser),
    .status     (status),
    .cmd        (cmd)
  );

  ebr_datapath #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_center_x (s_tdata[COORD_BITS-1:0]),
    .in_center_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_semi_a   (s_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS]),
    .in_semi_b   (s_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_last  (m_tlast)
  );

  // Pack the point fields, point_x in the low bits.
  assign m_tdata = M_DATA_W'({point_y, point_x});

  // A step taken while an ellipse is in progress keeps the input closed next cycle.
  a_step_closes_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ebr_pkg::CMD_STEP) && status.busy |=> !s_tready)
    else $error("input open after an accepted step");

  // A start marks the ellipse busy and reopens the input after the set-up cycles.
  a_start_setup: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ebr_pkg::CMD_START) |=> status.busy ##3 s_tready)
    else $error("start set-up sequence broken");

  // The controller never overwrites a point that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_point |-> status.out_free)
    else $error("point loaded over a waiting point");

  // State is only committed on the last point of a step.
  a_commit_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> cmd.load_point && (cmd.point_idx == ebr_pkg::PT_LAST))
    else $error("step committed before its last point");

endmodule

`default_nettype wire

// ===== hw/rtl/ebr_datapath.sv =====
// Datapath: held ellipse state, shared products, decision terms and the output point register.
`timescale 1ns / 1ps
`default_nettype none

module ebr_datapath #(
  parameter int COORD_BITS = ebr_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = ebr_pkg::AXIS_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ebr_pkg::ebr_cmd_t            cmd,
  output ebr_pkg::ebr_status_t              status,
  input  wire logic [COORD_BITS-1:0]        in_center_x,
  input  wire logic [COORD_BITS-1:0]        in_center_y,
  input  wire logic [AXIS_BITS-1:0]         in_semi_a,
  input  wire logic [AXIS_BITS-1:0]         in_semi_b,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS+1:0]      point_x,
  output logic signed [COORD_BITS+1:0]      point_y,
  output logic                              point_last
);

  localparam int OUT_W = COORD_BITS + 2;
  localparam int X_W   = AXIS_BITS + 1;
  localparam int Y_W   = AXIS_BITS + 2;
  localparam int SQ_W  = 2 * AXIS_BITS;
  localparam int PRD_W = 3 * AXIS_BITS + 1;
  localparam int ERR_W = 3 * AXIS_BITS + 5;
  localparam int T_W   = ERR_W + 2;

  // Held ellipse state.
  logic [COORD_BITS-1:0]   center_x;
  logic [COORD_BITS-1:0]   center_y;
  logic [AXIS_BITS-1:0]    semi_a;
  logic [X_W-1:0]          step_x;
  logic signed [Y_W-1:0]   step_y;
  logic signed [ERR_W-1:0] error_term;
  logic [SQ_W-1:0]         a_squared;
  logic [SQ_W-1:0]         b_squared;
  logic                    busy;

  // Free-running product and decision-term registers.
  logic [PRD_W-1:0]        prod_ay;
  logic [PRD_W-1:0]        prod_bx;
  logic                    dt_neg;
  logic signed [T_W-1:0]   h_term;
  logic signed [T_W-1:0]   v_term;

  // Combinational terms.
  logic [X_W-1:0]          y_mag;
  logic signed [T_W-1:0]   d_ext;
  logic signed [T_W-1:0]   aa_ext;
  logic signed [T_W-1:0]   bb_ext;
  logic signed [T_W-1:0]   ay_ext;
  logic signed [T_W-1:0]   bx_ext;
  logic signed [T_W-1:0]   dt_next;
  logic signed [T_W-1:0]   h_next;
  logic signed [T_W-1:0]   v_next;
  logic signed [T_W-1:0]   d_upd;
  logic                    err_neg;
  logic                    err_zero;
  logic                    inc_x;
  logic                    dec_y;
  logic                    fin;
  logic [OUT_W-1:0]        cx_o;
  logic [OUT_W-1:0]        cy_o;
  logic [OUT_W-1:0]        x_o;
  logic [OUT_W-1:0]        y_o;
  logic [OUT_W-1:0]        px_next;
  logic [OUT_W-1:0]        py_next;

  // y is never negative while an ellipse is in progress.
  assign y_mag  = step_y[AXIS_BITS:0];
  assign d_ext  = T_W'(error_term);
  assign aa_ext = $signed(T_W'(a_squared));
  assign bb_ext = $signed(T_W'(b_squared));
  assign ay_ext = $signed(T_W'(prod_ay));
  assign bx_ext = $signed(T_W'(prod_bx));

  // Tie-break term, chosen by the sign of the error, and the two move increments.
  assign err_neg  = error_term[ERR_W-1];
  assign err_zero = (error_term == '0);
  assign dt_next  = err_neg ? ((d_ext <<< 1) + (ay_ext <<< 1) - aa_ext)
                            : ((d_ext <<< 1) - (bx_ext <<< 1) - bb_ext);
  assign h_next   = (bx_ext <<< 1) + (bb_ext <<< 1) + bb_ext;
  assign v_next   = (aa_ext <<< 1) + aa_ext - (ay_ext <<< 1);

  // Move decision: horizontal, vertical or both.
  assign inc_x = !(!err_neg && !err_zero && !dt_neg);
  assign dec_y = !(err_neg && dt_neg);
  assign fin   = dec_y && (step_y == '0);
  assign d_upd = d_ext + (inc_x ? h_term : '0) + (dec_y ? v_term : '0);

  // Mirrored point for the selected quadrant.
  assign cx_o    = OUT_W'(center_x);
  assign cy_o    = OUT_W'(center_y);
  assign x_o     = OUT_W'(step_x);
  assign y_o     = OUT_W'(step_y);
  assign px_next = cmd.point_idx[1] ? (cx_o - x_o) : (cx_o + x_o);
  assign py_next = cmd.point_idx[0] ? (cy_o - y_o) : (cy_o + y_o);

  assign status.busy     = busy;
  assign status.out_free = !out_valid || out_ready;

  // Product and decision pipeline, refreshed every cycle from the held state.
  always_ff @(posedge clk) begin
    prod_ay <= PRD_W'(a_squared) * PRD_W'(y_mag);
    prod_bx <= PRD_W'(b_squared) * PRD_W'(step_x);
    dt_neg  <= dt_next[T_W-1];
    h_term  <= h_next;
    v_term  <= v_next;
  end

  // Held ellipse state: start, set-up and step updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.load_start) begin
      busy <= 1'b1;
    end else if (cmd.commit && fin) begin
      busy <= 1'b0;
    end
    if (cmd.load_start) begin
      center_x <= in_center_x;
      center_y <= in_center_y;
      semi_a   <= in_semi_a;
      step_x   <= '0;
      step_y   <= Y_W'(in_semi_b);
    end else if (cmd.commit) begin
      step_x   <= step_x + X_W'(inc_x);
      step_y   <= step_y - Y_W'(dec_y);
    end
    if (cmd.square) begin
      a_squared <= SQ_W'(semi_a) * SQ_W'(semi_a);
      b_squared <= SQ_W'(step_y[AXIS_BITS-1:0]) * SQ_W'(step_y[AXIS_BITS-1:0]);
    end
    if (cmd.init_err) begin
      error_term <= ERR_W'(aa_ext + bb_ext - (ay_ext <<< 1));
    end else if (cmd.commit) begin
      error_term <= ERR_W'(d_upd);
    end
  end

  // Output register: holds one point until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_point) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_point) begin
      point_x    <= $signed(px_next);
      point_y    <= $signed(py_next);
      point_last <= (cmd.point_idx == ebr_pkg::PT_LAST) && fin;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ebr_ctrl.sv =====
// Controller state machine: sequences start set-up and the four point emissions of a step.
`timescale 1ns / 1ps
`default_nettype none

module ebr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_command,
  input  wire ebr_pkg::ebr_status_t status,
  output ebr_pkg::ebr_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_PROD,
    ST_ERR,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic [ebr_pkg::PT_W-1:0] pt_idx;

  assign in_ready = (state == ST_IDLE);

  // Datapath commands decoded from the state.
  always_comb begin
    cmd           = '0;
    cmd.point_idx = pt_idx;
    unique case (state)
      ST_IDLE: begin
        cmd.load_start = in_valid && (in_command == ebr_pkg::CMD_START);
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
      end
      ST_PROD: begin
        cmd = cmd;
      end
      ST_ERR: begin
        cmd.init_err = 1'b1;
      end
      ST_EMIT: begin
        cmd.load_point = status.out_free;
        cmd.commit     = status.out_free && (pt_idx == ebr_pkg::PT_LAST);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State and point counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pt_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_command == ebr_pkg::CMD_START) begin
              state <= ST_SQUARE;
            end else if (status.busy) begin
              state  <= ST_EMIT;
              pt_idx <= '0;
            end
          end
        end
        ST_SQUARE: begin
          state <= ST_PROD;
        end
        ST_PROD: begin
          state <= ST_ERR;
        end
        ST_ERR: begin
          state <= ST_IDLE;
        end
        ST_EMIT: begin
          if (status.out_free) begin
            pt_idx <= pt_idx + (ebr_pkg::PT_W)'(1);
            if (pt_idx == ebr_pkg::PT_LAST) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
